/* src/psht_pkg.sv */
// Package for the priority sorted handler table.
// Types, codes and widths shared by the interfaces, the entry store and the top level.
`default_nettype none
package psht_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int KEY_W           = 32;
  localparam int PRIO_W          = 32;
  localparam int COUNT_W         = 6;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_DUP     = 3'd2,
    ST_FULL    = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  typedef struct packed {
    logic        [KEY_W-1:0]  key;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

endpackage
`default_nettype wire

/* src/psht_req_if.sv */
// Request channel of the handler table: valid/ready plus one operation.
// Depends on psht_pkg.
`default_nettype none
interface psht_req_if;
  import psht_pkg::*;

  logic                     valid;
  logic                     ready;
  action_t                  action;
  logic        [KEY_W-1:0]  handle;
  logic signed [PRIO_W-1:0] priority_req;

  modport source (output valid, action, handle, priority_req, input ready);
  modport sink   (input valid, action, handle, priority_req, output ready);
endinterface
`default_nettype wire

/* src/psht_rsp_if.sv */
// Response channel of the handler table: valid/ready plus one result.
// Depends on psht_pkg.
`default_nettype none
interface psht_rsp_if;
  import psht_pkg::*;

  logic               valid;
  logic               ready;
  status_t            status;
  logic               present;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, status, present, entry_count, input ready);
  modport sink   (input valid, status, present, entry_count, output ready);
endinterface
`default_nettype wire

/* src/psht_store.sv */
// Entry store of the handler table: one write port, one registered read port.
// Depends on psht_pkg.
`default_nettype none
module psht_store #(
  parameter int DEPTH = psht_pkg::TABLE_DEPTH_DEF
) (
  input  wire                          clk,
  input  wire                          wr_en,
  input  wire  [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire  psht_pkg::entry_t       wr_data,
  input  wire  [$clog2(DEPTH)-1:0]     rd_addr,
  output psht_pkg::entry_t             rd_data
);
  import psht_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* src/priority_sorted_handler_table.sv */
// Top level of the priority sorted handler table: sequencer around one entry store.
// Depends on psht_pkg, psht_req_if, psht_rsp_if and psht_store.
//
// Usage:
//   req carries one operation (add, remove, find, clear) with a key and, for add,
//   a signed priority. rsp returns exactly one result per request transaction:
//   status, present (find only) and the entry count after the operation.
//   Entries are kept in descending priority; equal priorities keep arrival order.
// Timing:
//   One request at a time; req.ready is high only while idle. A find, add or
//   remove makes one pass that reads every entry through the single read port of
//   the store; a successful add or remove then moves the entries behind the insert
//   or remove point one slot per cycle through the same port. Clear, zero keys and
//   an empty table skip the pass.
// Reset:
//   rst (synchronous) empties the table at once; stored data is not cleared,
//   only entries below the count are ever read.
// Stalls:
//   A result is held in the output register until rsp.ready; no new request
//   is taken meanwhile.
`default_nettype none
module priority_sorted_handler_table #(
  parameter int TABLE_DEPTH = psht_pkg::TABLE_DEPTH_DEF
) (
  input  wire        clk,
  input  wire        rst,
  psht_req_if.sink   req,
  psht_rsp_if.source rsp
);
  import psht_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_t;

  state_t                   state;
  action_t                  act_q;
  logic        [KEY_W-1:0]  key_q;
  logic signed [PRIO_W-1:0] prio_q;
  logic [CW-1:0]            occ;        // number of valid entries
  logic [CW-1:0]            scan_idx;   // next entry to read during the scan
  logic                     pend;       // read data of entry 'tag' arrives now
  logic [AW-1:0]            tag;
  logic                     found;      // key already seen in the scan
  logic [AW-1:0]            fpos;
  logic                     ins_found;  // first lower-priority entry seen
  logic [CW-1:0]            ipos;       // insert slot
  logic [AW-1:0]            src;        // next entry to move
  logic                     dir_up;     // remove: entries move toward slot 0
  logic [CW-1:0]            mv_left;    // moves still to issue
  status_t                  status_q;
  logic                     present_q;

  // store ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;

  // per-entry compare on the read data
  logic          match_now;
  logic          gt_now;
  logic          last_now;
  logic          found_c;
  logic [AW-1:0] fpos_c;
  logic [CW-1:0] ipos_c;

  psht_store #(.DEPTH(TABLE_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_addr   = (state == S_SCAN) ? scan_idx[AW-1:0] : src;
  assign match_now = pend && (rd_data.key == key_q);
  assign gt_now    = pend && (prio_q > rd_data.prio);
  assign last_now  = pend && (CW'(tag) == occ - CW'(1));
  assign found_c   = found || match_now;
  assign fpos_c    = found ? fpos : tag;
  assign ipos_c    = ins_found ? ipos : (gt_now ? CW'(tag) : occ);

  // Moves write the entry just read one slot over; the final add writes the new entry.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = src;
    wr_data = rd_data;
    if (state == S_SHIFT) begin
      if (pend) begin
        wr_en   = 1'b1;
        wr_addr = dir_up ? (tag - AW'(1)) : (tag + AW'(1));
      end else if (mv_left == '0 && act_q == ACT_ADD) begin
        wr_en        = 1'b1;
        wr_addr      = ipos[AW-1:0];
        wr_data.key  = key_q;
        wr_data.prio = prio_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            act_q     <= req.action;
            key_q     <= req.handle;
            prio_q    <= req.priority_req;
            found     <= 1'b0;
            ins_found <= 1'b0;
            pend      <= 1'b0;
            present_q <= 1'b0;
            scan_idx  <= '0;
            status_q  <= ST_OK;
            if (req.action == ACT_CLEAR) begin
              occ   <= '0;
              state <= S_RESP;
            end else if (req.handle == '0) begin
              if (req.action == ACT_ADD) begin
                status_q <= ST_ZERO;
              end else if (req.action == ACT_REMOVE) begin
                status_q <= ST_MISSING;
              end
              state <= S_RESP;
            end else if (occ == '0) begin
              if (req.action == ACT_ADD) begin
                ipos    <= '0;
                mv_left <= '0;
                state   <= S_SHIFT;
              end else begin
                if (req.action == ACT_REMOVE) begin
                  status_q <= ST_MISSING;
                end
                state <= S_RESP;
              end
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (scan_idx < occ) begin
            scan_idx <= scan_idx + CW'(1);
          end
          pend <= (scan_idx < occ);
          tag  <= scan_idx[AW-1:0];
          if (match_now && !found) begin
            found <= 1'b1;
            fpos  <= tag;
          end
          if (gt_now && !ins_found) begin
            ins_found <= 1'b1;
            ipos      <= CW'(tag);
          end
          if (last_now) begin
            pend <= 1'b0;
            unique case (act_q)
              ACT_FIND: begin
                present_q <= found_c;
                state     <= S_RESP;
              end
              ACT_REMOVE: begin
                if (!found_c) begin
                  status_q <= ST_MISSING;
                  state    <= S_RESP;
                end else begin
                  src     <= fpos_c + AW'(1);
                  dir_up  <= 1'b1;
                  mv_left <= occ - CW'(1) - CW'(fpos_c);
                  state   <= S_SHIFT;
                end
              end
              ACT_ADD: begin
                if (found_c) begin
                  status_q <= ST_DUP;
                  state    <= S_RESP;
                end else if (occ == CW'(TABLE_DEPTH)) begin
                  status_q <= ST_FULL;
                  state    <= S_RESP;
                end else begin
                  src     <= AW'(occ - CW'(1));
                  dir_up  <= 1'b0;
                  mv_left <= occ - ipos_c;
                  ipos    <= ipos_c;
                  state   <= S_SHIFT;
                end
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end

        S_SHIFT: begin
          if (mv_left != '0) begin
            src     <= dir_up ? (src + AW'(1)) : (src - AW'(1));
            mv_left <= mv_left - CW'(1);
            pend    <= 1'b1;
            tag     <= src;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              occ   <= (act_q == ACT_ADD) ? (occ + CW'(1)) : (occ - CW'(1));
              state <= S_RESP;
            end
          end
        end

        S_RESP: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = (state == S_RESP);
  assign rsp.status      = status_q;
  assign rsp.present     = present_q;
  assign rsp.entry_count = COUNT_W'(occ);

endmodule
`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for priority_sorted_handler_table.
// Depends on psht_pkg, psht_req_if, psht_rsp_if and the RTL top level.
// A shadow copy of the sorted table predicts every response transaction.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import psht_pkg::*;

  localparam int DEPTH      = TABLE_DEPTH_DEF;
  localparam int RANDOM_OPS = 450;
  localparam int POOL_MAX   = 64;
  localparam logic signed [PRIO_W-1:0] PRIO_MAX = 32'h7FFF_FFFF;
  localparam logic signed [PRIO_W-1:0] PRIO_MIN = 32'h8000_0000;

  // One request transaction as the driver sends it.
  typedef struct {
    action_t                  action;
    logic        [KEY_W-1:0]  handle;
    logic signed [PRIO_W-1:0] prio;
  } table_op_t;

  // One response transaction as the monitor expects it.
  typedef struct {
    status_t            status;
    logic               present;
    logic [COUNT_W-1:0] entry_count;
  } table_reply_t;

  logic clk;
  logic rst;

  psht_req_if req ();
  psht_rsp_if rsp ();

  priority_sorted_handler_table #(
    .TABLE_DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // ---------------------------------------------------------------------------
  // Shadow table: keys and priorities in descending priority order, ties kept
  // in arrival order. Only slots below shadow_count are meaningful.
  // ---------------------------------------------------------------------------
  logic        [KEY_W-1:0]  shadow_keys  [DEPTH];
  logic signed [PRIO_W-1:0] shadow_prios [DEPTH];
  int                       shadow_count;

  table_op_t    queued_ops [$];      // requests not yet handed to the driver
  table_reply_t replies_due [$];     // predicted responses, oldest first
  table_op_t    in_flight;           // request currently on the req channel
  logic [KEY_W-1:0] key_pool [$];    // keys likely stored, for hits and dups
  int           gap_left;
  int           stall_left;
  int           ops_made;
  bit           failed;

  function automatic void wipe_shadow();
    for (int i = 0; i < DEPTH; i++) begin
      shadow_keys[i]  = '0;
      shadow_prios[i] = '0;
    end
    shadow_count = 0;
  endfunction

  function automatic int slot_of(logic [KEY_W-1:0] key);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_keys[i] == key) return i;
    end
    return -1;
  endfunction

  // Applies one operation to the shadow table and returns its response.
  function automatic table_reply_t apply_table_op(table_op_t op);
    table_reply_t reply;
    int           pos;
    int           slot;
    reply.status  = ST_OK;
    reply.present = 1'b0;
    case (op.action)
      ACT_ADD: begin
        if (op.handle == '0) begin
          reply.status = ST_ZERO;
        end else if (slot_of(op.handle) >= 0) begin
          reply.status = ST_DUP;
        end else if (shadow_count >= DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          // insert before the first entry with a strictly lower priority
          pos = shadow_count;
          for (int i = shadow_count - 1; i >= 0; i--) begin
            if (op.prio > shadow_prios[i]) pos = i;
          end
          for (int i = shadow_count; i > pos; i--) begin
            shadow_keys[i]  = shadow_keys[i-1];
            shadow_prios[i] = shadow_prios[i-1];
          end
          shadow_keys[pos]  = op.handle;
          shadow_prios[pos] = op.prio;
          shadow_count++;
        end
      end
      ACT_REMOVE: begin
        slot = (op.handle == '0) ? -1 : slot_of(op.handle);
        if (slot < 0) begin
          reply.status = ST_MISSING;
        end else begin
          for (int i = slot; i + 1 < shadow_count; i++) begin
            shadow_keys[i]  = shadow_keys[i+1];
            shadow_prios[i] = shadow_prios[i+1];
          end
          shadow_count--;
          shadow_keys[shadow_count]  = '0;
          shadow_prios[shadow_count] = '0;
        end
      end
      ACT_FIND: begin
        // a zero key is never stored, and find always reports ok
        reply.present = (op.handle != '0) && (slot_of(op.handle) >= 0);
      end
      default: begin
        wipe_shadow();
      end
    endcase
    reply.entry_count = shadow_count[COUNT_W-1:0];
    return reply;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_op(action_t act, logic [KEY_W-1:0] h, logic signed [PRIO_W-1:0] p);
    table_op_t op;
    op.action = act;
    op.handle = h;
    op.prio   = p;
    queued_ops.push_back(op);
  endtask

  function automatic logic signed [PRIO_W-1:0] draw_prio();
    // a small set of values makes ties and extremes common
    case ($urandom_range(0, 9))
      0:       return PRIO_MAX;
      1:       return PRIO_MIN;
      2:       return '0;
      3:       return -1;
      4:       return 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void remember_key(logic [KEY_W-1:0] k);
    key_pool.push_back(k);
    if (key_pool.size() > POOL_MAX) key_pool.delete(0);
  endfunction

  // Adds lean toward fresh keys so the table fills; removes and finds lean
  // toward keys already added so they mostly hit.
  function automatic logic [KEY_W-1:0] pick_key(action_t act);
    int               roll;
    int               idx;
    int               pool_pct;
    logic [KEY_W-1:0] k;
    roll     = $urandom_range(0, 99);
    pool_pct = (act == ACT_ADD) ? 20 : 70;
    if (roll < 5) return '0;
    if (roll < 5 + pool_pct && key_pool.size() != 0) begin
      idx = $urandom_range(0, key_pool.size() - 1);
      k   = key_pool[idx];
      if (act == ACT_REMOVE) key_pool.delete(idx);
      return k;
    end
    k = $urandom;
    if (act == ACT_ADD && k != '0) remember_key(k);
    return k;
  endfunction

  task automatic queue_random(int n, int add_pct, int rem_pct);
    int      roll;
    action_t act;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        act = ACT_CLEAR;
        key_pool.delete();
      end else if (roll < 2 + add_pct) begin
        act = ACT_ADD;
      end else if (roll < 2 + add_pct + rem_pct) begin
        act = ACT_REMOVE;
      end else begin
        act = ACT_FIND;
      end
      queue_op(act, (act == ACT_CLEAR) ? KEY_W'($urandom) : pick_key(act), draw_prio());
      ops_made++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Driver: presents queued requests, with a random gap after some accepted
  // transactions. Prediction happens at the accepting edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : req_driver
    table_op_t nxt;
    if (rst) begin
      req.valid <= 1'b0;
      gap_left  <= 0;
    end else begin
      if (req.valid && req.ready) replies_due.push_back(apply_table_op(in_flight));
      if (!req.valid || req.ready) begin
        if (gap_left != 0) begin
          req.valid <= 1'b0;
          gap_left  <= gap_left - 1;
        end else if (queued_ops.size() != 0) begin
          nxt              = queued_ops.pop_front();
          in_flight        <= nxt;
          req.action       <= nxt.action;
          req.handle       <= nxt.handle;
          req.priority_req <= nxt.prio;
          req.valid        <= 1'b1;
          // about a third of items draw a gap, which may be zero; the rest run back to back
          gap_left         <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: after some responses, stalls ready on the next pending result,
  // then checks each response transaction against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : rsp_monitor
    table_reply_t want;
    int           s;
    if (rst) begin
      rsp.ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      s = stall_left;
      if (rsp.valid && rsp.ready) begin
        if (replies_due.size() == 0) begin
          $error("response with no request outstanding: status %0d count %0d",
                 rsp.status, rsp.entry_count);
          failed = 1'b1;
        end else begin
          want = replies_due.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            failed = 1'b1;
          end
          if (rsp.present !== want.present) begin
            $error("present: expected %0d, got %0d", want.present, rsp.present);
            failed = 1'b1;
          end
          if (rsp.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   rsp.entry_count);
            failed = 1'b1;
          end
        end
        s = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0;
      end else if (rsp.valid && s != 0) begin
        s = s - 1;
      end
      rsp.ready  <= (s == 0);
      stall_left <= s;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: far beyond the slowest legal run (about 500 transactions,
  // including gaps and stalls).
  // ---------------------------------------------------------------------------
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [KEY_W-1:0] k;
    rst              = 1'b1;
    failed           = 1'b0;
    ops_made         = 0;
    req.valid        = 1'b0;
    req.action       = ACT_ADD;
    req.handle       = '0;
    req.priority_req = '0;
    rsp.ready        = 1'b0;
    in_flight        = '{ACT_ADD, '0, '0};
    wipe_shadow();

    // Directed: empty table, zero key, extremes, ties, duplicates, head /
    // middle / tail removal, clear. Non-add priorities are filler the table ignores.
    queue_op(ACT_FIND,   '0,           $urandom);
    queue_op(ACT_REMOVE, '0,           $urandom);
    queue_op(ACT_REMOVE, 32'h0000_0005, $urandom);
    queue_op(ACT_ADD,    '0,           32'sd5);
    queue_op(ACT_ADD,    32'hFFFF_FFFF, PRIO_MAX);
    queue_op(ACT_ADD,    32'h0000_0001, PRIO_MIN);
    queue_op(ACT_ADD,    32'h8000_0000, '0);
    queue_op(ACT_ADD,    32'h1234_5678, '0);     // tie: goes after the older zero
    queue_op(ACT_ADD,    32'h8000_0000, 32'sd3); // duplicate
    queue_op(ACT_FIND,   32'hFFFF_FFFF, $urandom);
    queue_op(ACT_FIND,   '0,           $urandom);
    queue_op(ACT_FIND,   32'hDEAD_BEEF, $urandom);
    queue_op(ACT_REMOVE, 32'h8000_0000, $urandom);
    queue_op(ACT_REMOVE, 32'h8000_0000, $urandom);
    queue_op(ACT_REMOVE, 32'hFFFF_FFFF, $urandom);
    queue_op(ACT_REMOVE, 32'h0000_0001, $urandom);
    queue_op(ACT_ADD,    32'h5555_AAAA, -32'sd1);
    queue_op(ACT_CLEAR,  32'hFFFF_FFFF, PRIO_MIN);
    queue_op(ACT_FIND,   32'h1234_5678, $urandom);
    queue_op(ACT_ADD,    32'hAAAA_5555, PRIO_MAX);
    queue_op(ACT_CLEAR,  '0,           $urandom);

    // Fill past capacity with fresh keys so the full-table reject is reached.
    for (int i = 0; i < DEPTH + 4; i++) begin
      k = $urandom;
      if (k == '0) k = 32'h0000_0001;
      remember_key(k);
      queue_op(ACT_ADD, k, draw_prio());
      ops_made++;
    end

    // Random episodes: filling, draining, and mixed traffic.
    while (ops_made < RANDOM_OPS) begin
      case ($urandom_range(0, 2))
        0:       queue_random(50, 80, 8);
        1:       queue_random(40, 10, 65);
        default: queue_random(30, 35, 35);
      endcase
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // drain: everything sent, accepted and answered
    @(negedge clk);
    while (queued_ops.size() != 0 || req.valid || replies_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (80) @(negedge clk);

    if (!failed && replies_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
